>>> rtl/eve_pkg.sv
// ----------------------------------------------------------------------------
// Encoder velocity estimator package
// Shared types, register indexes and constants for the velocity estimator.
// ----------------------------------------------------------------------------
`default_nettype none

package eve_pkg;

    localparam int CH_W             = 5;
    localparam int DATA_W           = 32;
    localparam int GAIN_W           = 10;
    localparam int MASK_W           = 18;
    localparam int CFG_IDX_W        = 8;
    localparam int DEF_NUM_CHANNELS = 18;

    localparam logic [GAIN_W-1:0] RESET_RATE_GAIN   = 10'd50;
    localparam logic [MASK_W-1:0] RESET_INVERT_MASK = 18'd173376;

    localparam logic [CFG_IDX_W-1:0] CFG_RATE_GAIN   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_MASK = 8'd1;

    // Reciprocal of ten for 32-bit unsigned operands: q = (a * RECIP_TEN) >> RECIP_SHIFT.
    localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    typedef struct packed {
        logic [CH_W-1:0]          channel;
        logic signed [DATA_W-1:0] count;
    } t_in_item;

    typedef struct packed {
        logic [CH_W-1:0]          channel_out;
        logic signed [DATA_W-1:0] velocity;
    } t_out_item;

    typedef struct packed {
        logic [DATA_W-1:0] x1;
        logic [DATA_W-1:0] x2;
        logic [DATA_W-1:0] vel;
    } t_entry;

    typedef struct packed {
        logic              ok;
        logic [CH_W-1:0]   ch;
        logic [DATA_W-1:0] x0;
        logic [DATA_W-1:0] x1;
    } t_tag;

endpackage

`default_nettype wire

>>> rtl/encoder_velocity_estimator.sv
// A request passes through stage registers s1 to s5 and then the output register.
// Throughput: one request per cycle while the output is not stalled, unless its channel
// matches an in-range request still held in s1 to s5. Such a request waits for the
// earlier one's memory write-back, which happens as that one leaves s5.
// Reset is synchronous; per-channel valid bits make history and velocity read as zero
// immediately, so no clearing pass is needed.
// ----------------------------------------------------------------------------
// Encoder velocity estimator
// Three-point backward difference velocity with a 9/10 first-order filter,
// per-channel state held in one synchronous memory.
// ----------------------------------------------------------------------------
`default_nettype none

module encoder_velocity_estimator #(
    parameter int NUM_CHANNELS = eve_pkg::DEF_NUM_CHANNELS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire eve_pkg::t_in_item             i_in_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output eve_pkg::t_out_item                 o_out_data,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [eve_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]                   i_cfg_data
);
    import eve_pkg::*;

    localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    t_entry            mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] r_vld;

    logic [GAIN_W-1:0] r_gain;
    logic [MASK_W-1:0] r_invert;

    logic              r_s1_v, r_s2_v, r_s3_v, r_s4_v, r_s5_v, r_out_v;
    t_tag              r_s1_tag, r_s2_tag, r_s3_tag, r_s4_tag, r_s5_tag;
    t_entry            r_rd;
    logic              r_rd_ok;

    logic signed [34:0] r_s2_d;
    logic [31:0]        r_s2_a;
    logic               r_s2_neg;

    logic [63:0]        r_s3_prod;
    logic signed [45:0] r_s3_m;
    logic [31:0]        r_s3_a;
    logic               r_s3_neg;

    logic [31:0]        r_s4_q;
    logic               r_s4_ne;
    logic [31:0]        r_s4_a;
    logic               r_s4_neg;
    logic signed [45:0] r_s4_m;

    logic signed [32:0] r_s5_f;
    logic signed [45:0] r_s5_m;

    t_out_item          r_out;

    logic rdy_out, rdy5, rdy4, rdy3, rdy2, rdy1;
    logic in_ok, in_inv, hazard, in_acc, wr_en;
    logic [AW+CH_W-1:0] in_ext, wr_ext;
    logic [AW-1:0]      in_addr, wr_addr;
    logic [MASK_W-1:0]  inv_sh;
    logic [31:0]        in_x0;

    logic [31:0]        s1_x1, s1_x2, s1_vp;
    logic signed [34:0] e0, e1, e2, s1_d;
    logic [31:0]        s1_a;

    logic [28:0]        s3_q;
    logic [31:0]        s3_tenq;
    logic [31:0]        s4_fmag;
    logic signed [32:0] s4_f;
    logic signed [46:0] s5_sum;
    logic [31:0]        s5_sat;

    assign rdy_out = !r_out_v || i_out_ready;
    assign rdy5    = !r_s5_v || rdy_out;
    assign rdy4    = !r_s4_v || rdy5;
    assign rdy3    = !r_s3_v || rdy4;
    assign rdy2    = !r_s2_v || rdy3;
    assign rdy1    = !r_s1_v || rdy2;

    assign in_ok   = {2'b00, i_in_data.channel} < 7'(NUM_CHANNELS);
    assign in_ext  = {{AW{1'b0}}, i_in_data.channel};
    assign in_addr = in_ext[AW-1:0];
    assign inv_sh  = r_invert >> i_in_data.channel;
    assign in_inv  = inv_sh[0];
    assign in_x0   = in_inv ? (32'd0 - i_in_data.count) : i_in_data.count;

    assign hazard = in_ok && (
        (r_s1_v && r_s1_tag.ok && r_s1_tag.ch == i_in_data.channel) ||
        (r_s2_v && r_s2_tag.ok && r_s2_tag.ch == i_in_data.channel) ||
        (r_s3_v && r_s3_tag.ok && r_s3_tag.ch == i_in_data.channel) ||
        (r_s4_v && r_s4_tag.ok && r_s4_tag.ch == i_in_data.channel) ||
        (r_s5_v && r_s5_tag.ok && r_s5_tag.ch == i_in_data.channel));

    assign o_in_ready  = rdy1 && !hazard;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    assign wr_ext  = {{AW{1'b0}}, r_s5_tag.ch};
    assign wr_addr = wr_ext[AW-1:0];
    assign wr_en   = rdy_out && r_s5_v && r_s5_tag.ok;

    always_comb begin
        s1_x1 = r_rd_ok ? r_rd.x1 : 32'd0;
        s1_x2 = r_rd_ok ? r_rd.x2 : 32'd0;
        s1_vp = r_rd_ok ? r_rd.vel : 32'd0;
        e0    = 35'($signed(r_s1_tag.x0));
        e1    = 35'($signed(s1_x1));
        e2    = 35'($signed(s1_x2));
        s1_d  = (e0 <<< 1) + e0 - (e1 <<< 2) + e2;
        s1_a  = s1_vp[31] ? (32'd0 - s1_vp) : s1_vp;
    end

    always_comb begin
        s3_q    = r_s3_prod[63:RECIP_SHIFT];
        s3_tenq = 32'({s3_q, 3'b000}) + 32'({s3_q, 1'b0});
        s4_fmag = r_s4_a - r_s4_q - 32'(r_s4_ne);
        s4_f    = r_s4_neg ? -$signed({1'b0, s4_fmag}) : $signed({1'b0, s4_fmag});
        s5_sum  = 47'(r_s5_f) + 47'(r_s5_m);
        if (s5_sum > 47'sh7FFF_FFFF) begin
            s5_sat = 32'h7FFF_FFFF;
        end else if (s5_sum < -47'sh8000_0000) begin
            s5_sat = 32'h8000_0000;
        end else begin
            s5_sat = s5_sum[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= RESET_RATE_GAIN;
            r_invert <= RESET_INVERT_MASK;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_RATE_GAIN: begin
                    r_gain <= i_cfg_data[GAIN_W-1:0];
                end
                CFG_INVERT_MASK: begin
                    r_invert <= i_cfg_data[MASK_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_s4_v  <= 1'b0;
            r_s5_v  <= 1'b0;
            r_out_v <= 1'b0;
            r_vld   <= '0;
        end else begin
            if (rdy1) begin
                r_s1_v <= in_acc;
            end
            if (rdy2) begin
                r_s2_v <= r_s1_v;
            end
            if (rdy3) begin
                r_s3_v <= r_s2_v;
            end
            if (rdy4) begin
                r_s4_v <= r_s3_v;
            end
            if (rdy5) begin
                r_s5_v <= r_s4_v;
            end
            if (rdy_out) begin
                r_out_v <= r_s5_v;
            end
            if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd    <= mem[in_addr];
            r_rd_ok <= in_ok && r_vld[in_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= '{x1: r_s5_tag.x0, x2: r_s5_tag.x1, vel: s5_sat};
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_s1_tag <= '{ok: in_ok, ch: i_in_data.channel, x0: in_x0, x1: 32'd0};
        end
        if (rdy2) begin
            r_s2_tag    <= '{ok: r_s1_tag.ok, ch: r_s1_tag.ch, x0: r_s1_tag.x0, x1: s1_x1};
            r_s2_d      <= s1_d;
            r_s2_a      <= s1_a;
            r_s2_neg    <= s1_vp[31];
        end
        if (rdy3) begin
            r_s3_tag  <= r_s2_tag;
            r_s3_prod <= 64'(r_s2_a) * 64'(RECIP_TEN);
            r_s3_m    <= 46'(r_s2_d) * 46'($signed({1'b0, r_gain}));
            r_s3_a    <= r_s2_a;
            r_s3_neg  <= r_s2_neg;
        end
        if (rdy4) begin
            r_s4_tag <= r_s3_tag;
            r_s4_q   <= 32'(s3_q);
            r_s4_ne  <= (r_s3_a != s3_tenq);
            r_s4_a   <= r_s3_a;
            r_s4_neg <= r_s3_neg;
            r_s4_m   <= r_s3_m;
        end
        if (rdy5) begin
            r_s5_tag <= r_s4_tag;
            r_s5_f   <= s4_f;
            r_s5_m   <= r_s4_m;
        end
        if (rdy_out) begin
            r_out.channel_out <= r_s5_tag.ch;
            r_out.velocity    <= r_s5_tag.ok ? s5_sat : 32'd0;
        end
    end

endmodule

`default_nettype wire

>>> verif/tb_encoder_velocity_estimator.sv
// ----------------------------------------------------------------------------
// Encoder velocity estimator testbench
// A short table of directed requests comes first. Random phases follow, with
// different gain and invert settings and different idle patterns on both the
// request and result ports. A predictor built into the bench computes the velocity of each
// request, and every result is checked field by field, in order.
// ----------------------------------------------------------------------------
module tb_encoder_velocity_estimator;
    timeunit 1ns;
    timeprecision 1ps;

    import eve_pkg::*;

    localparam int NUM_CH          = DEF_NUM_CHANNELS;
    localparam int LATENCY_CYCLES  = 5;
    localparam int DRAIN_CYCLES    = 2 * LATENCY_CYCLES;
    localparam int N_PHASES        = 8;
    localparam int ITEMS_PER_PHASE = 235;
    localparam int HOLD_PHASE      = 4;
    localparam int HOLD_CYCLES     = 300;
    localparam int STUCK_LIMIT     = 2000;
    localparam int WALK_STEP       = 1000;
    localparam int REPORT_LINES    = 40;
    localparam int SPARSE_PCT      = 19;
    localparam int DENSE_PCT       = 46;

    localparam logic signed [DATA_W-1:0] CNT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] CNT_MIN = 32'sh8000_0000;
    localparam longint VEL_MAX = longint'(CNT_MAX);
    localparam longint VEL_MIN = longint'(CNT_MIN);

    typedef struct packed {
        logic                     pinned;
        logic signed [DATA_W-1:0] velocity;
    } t_pin;

    typedef struct packed {
        logic [CH_W-1:0]          channel;
        logic signed [DATA_W-1:0] count;
        logic                     pinned;
        logic signed [DATA_W-1:0] velocity;
    } t_probe;

    localparam t_pin NO_PIN   = '0;
    localparam int   N_PROBES = 21;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    t_in_item             i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out_item            o_out_data;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0]          i_cfg_data  = '0;

    logic [GAIN_W-1:0] rate_gain;
    logic [MASK_W-1:0] invert_bits;
    logic [DATA_W-1:0] prior_count [NUM_CH][2];
    logic [DATA_W-1:0] held_velocity [NUM_CH];

    t_out_item velocity_due [$];
    t_pin      pinned_velocity [$];

    int unsigned mismatches   = 0;
    int unsigned stuck_cycles = 0;
    int unsigned tx_idle_pct  = 0;
    int unsigned rx_stall_pct = 0;
    int unsigned hold_left    = 0;
    logic        hold_go      = 1'b0;
    logic        hold_seen    = 1'b0;

    logic signed [DATA_W-1:0] walk [1 << CH_W] = '{default: '0};
    logic [CH_W-1:0]          last_channel = '0;

    t_probe probes [N_PROBES] = '{
        '{5'd0,  32'sd1,        1'b1, 32'sd150},
        '{5'd0,  32'sd1,        1'b0, 32'sd0},
        '{5'd0,  32'sd1,        1'b0, 32'sd0},
        '{5'd20, 32'sd12345,    1'b1, 32'sd0},
        '{5'd31, -32'sd1,       1'b1, 32'sd0},
        '{5'd18, CNT_MAX,       1'b1, 32'sd0},
        '{5'd1,  CNT_MAX,       1'b1, CNT_MAX},
        '{5'd2,  CNT_MIN,       1'b1, CNT_MIN},
        '{5'd6,  CNT_MIN,       1'b1, CNT_MIN},
        '{5'd8,  32'sd1,        1'b1, -32'sd150},
        '{5'd17, -32'sd1,       1'b1, 32'sd150},
        '{5'd16, -32'sd1,       1'b1, -32'sd150},
        '{5'd1,  CNT_MAX,       1'b0, 32'sd0},
        '{5'd1,  CNT_MIN,       1'b0, 32'sd0},
        '{5'd3,  32'sd0,        1'b1, 32'sd0},
        '{5'd4,  32'sd100,      1'b0, 32'sd0},
        '{5'd4,  32'sd200,      1'b0, 32'sd0},
        '{5'd4,  32'sd300,      1'b0, 32'sd0},
        '{5'd5,  32'sh5555_5555, 1'b0, 32'sd0},
        '{5'd5,  32'shAAAA_AAAA, 1'b0, 32'sd0},
        '{5'd7,  -32'sd1000,    1'b1, -32'sd150000}
    };

    encoder_velocity_estimator DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void clear_estimator();
        rate_gain   = RESET_RATE_GAIN;
        invert_bits = RESET_INVERT_MASK;
        foreach (held_velocity[c]) begin
            held_velocity[c]  = '0;
            prior_count[c][0] = '0;
            prior_count[c][1] = '0;
        end
    endfunction

    function automatic t_out_item estimate_velocity(input t_in_item req);
        t_out_item         res;
        logic [DATA_W-1:0] raw;
        longint            x0, x1, x2, diff, vprev, vnew;
        res.channel_out = req.channel;
        res.velocity    = '0;
        if (req.channel < NUM_CH) begin
            raw = req.count;
            if (invert_bits[req.channel]) begin
                raw = -raw;
            end
            x0    = signed'(raw);
            x1    = signed'(prior_count[req.channel][0]);
            x2    = signed'(prior_count[req.channel][1]);
            vprev = signed'(held_velocity[req.channel]);
            diff  = 3 * x0 - 4 * x1 + x2;
            vnew  = (9 * vprev) / 10 + diff * longint'(rate_gain);
            if (vnew > VEL_MAX) begin
                vnew = VEL_MAX;
            end
            if (vnew < VEL_MIN) begin
                vnew = VEL_MIN;
            end
            held_velocity[req.channel]  = vnew[DATA_W-1:0];
            prior_count[req.channel][1] = prior_count[req.channel][0];
            prior_count[req.channel][0] = raw;
            res.velocity = vnew[DATA_W-1:0];
        end
        return res;
    endfunction

    function automatic t_in_item next_sample();
        t_in_item    s;
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 5) begin
            s.channel = CH_W'($urandom_range((1 << CH_W) - 1, NUM_CH));
        end else if (roll < 25) begin
            s.channel = last_channel;
        end else begin
            s.channel = CH_W'($urandom_range(NUM_CH - 1));
        end
        last_channel = s.channel;
        roll = $urandom_range(99);
        if (roll < 70) begin
            walk[s.channel] = walk[s.channel] + (int'($urandom_range(2 * WALK_STEP)) - WALK_STEP);
            s.count = walk[s.channel];
        end else if (roll < 80) begin
            case ($urandom_range(4))
                0: s.count = CNT_MIN;
                1: s.count = CNT_MAX;
                2: s.count = '0;
                3: s.count = -1;
                default: s.count = 1;
            endcase
        end else begin
            s.count = $urandom;
        end
        return s;
    endfunction

    task automatic report_mismatch(input string field, input t_out_item got,
                                   input t_out_item want);
        mismatches++;
        if (mismatches <= REPORT_LINES) begin
            $display({"%0t: %s mismatch: got channel %0d velocity %0d, ",
                      "expected channel %0d velocity %0d"},
                     $time, field, got.channel_out, got.velocity, want.channel_out, want.velocity);
        end
    endtask

    task automatic push_request(input t_in_item req, input t_pin pin);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        pinned_velocity.push_back(pin);
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (velocity_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (hold_go != hold_seen) begin
            hold_seen   <= hold_go;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin : watch_ports
        t_out_item want;
        t_pin      pin;
        logic      out_fire, in_fire, cfg_fire;
        out_fire = (o_out_valid === 1'b1) && i_out_ready;
        in_fire  = i_in_valid && (o_in_ready === 1'b1);
        cfg_fire = i_cfg_valid && (o_cfg_ready === 1'b1);
        if (!i_rst_n) begin
            clear_estimator();
            stuck_cycles = 0;
        end else begin
            if (out_fire) begin
                if (velocity_due.size() == 0) begin
                    report_mismatch("unexpected result", o_out_data, '0);
                end else begin
                    want = velocity_due.pop_front();
                    if (o_out_data.channel_out !== want.channel_out) begin
                        report_mismatch("channel_out", o_out_data, want);
                    end
                    if (o_out_data.velocity !== want.velocity) begin
                        report_mismatch("velocity", o_out_data, want);
                    end
                end
            end
            if (cfg_fire) begin
                case (i_cfg_index)
                    CFG_RATE_GAIN: rate_gain = i_cfg_data[GAIN_W-1:0];
                    CFG_INVERT_MASK: invert_bits = i_cfg_data[MASK_W-1:0];
                    default: ;
                endcase
            end
            if (in_fire) begin
                want = estimate_velocity(i_in_data);
                pin  = pinned_velocity.pop_front();
                if (pin.pinned) begin
                    want.velocity = pin.velocity;
                end
                velocity_due.push_back(want);
            end
            if (out_fire || in_fire || cfg_fire) begin
                stuck_cycles = 0;
            end else begin
                stuck_cycles++;
            end
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("encoder_velocity_estimator regression: fail");
                $finish;
            end
        end
    end

    initial begin : stimulus
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (probes[k]) begin
            push_request(t_in_item'{probes[k].channel, probes[k].count},
                         t_pin'{probes[k].pinned, probes[k].velocity});
        end
        for (int p = 0; p < N_PHASES; p++) begin
            wait_idle();
            case (p)
                0: ;
                1: begin
                    write_register(CFG_RATE_GAIN, '1);
                    write_register(CFG_INVERT_MASK, '1);
                end
                2: begin
                    write_register(CFG_RATE_GAIN, '0);
                    write_register(CFG_INVERT_MASK, '0);
                end
                default: begin
                    write_register(CFG_RATE_GAIN, $urandom);
                    write_register(CFG_INVERT_MASK, $urandom);
                    write_register(CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1,
                                                             CFG_INVERT_MASK + 1)), $urandom);
                end
            endcase
            tx_idle_pct  = (p % 4 == 1) ? DENSE_PCT : (p % 4 == 3) ? SPARSE_PCT : 0;
            rx_stall_pct = (p % 4 == 2) ? DENSE_PCT : (p % 4 == 3) ? SPARSE_PCT : 0;
            if (p == HOLD_PHASE) begin
                hold_go <= ~hold_go;
            end
            repeat (ITEMS_PER_PHASE) push_request(next_sample(), NO_PIN);
        end
        wait_idle();
        if (mismatches == 0) begin
            $display("encoder_velocity_estimator regression: pass");
        end else begin
            $display("encoder_velocity_estimator regression: fail");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/eve_pkg.sv
rtl/encoder_velocity_estimator.sv
verif/tb_encoder_velocity_estimator.sv
